>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is held
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included
`define ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> sv/bchd_pkg.sv
// ----------------------------------------------------------------------------
// bchd_pkg
// Shared types and constants of the button click / hold detector.
// ----------------------------------------------------------------------------
package bchd_pkg;

  // Geometry
  localparam int NUM_PINS    = 8;                        // 1 .. 8
  localparam int COUNT_WIDTH = 14;                       // 4 .. 30
  localparam int SLOTS       = 2 * NUM_PINS;             // two events per pin
  localparam int QUEUE_DEPTH = 2;                        // power of two
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Fixed field widths
  localparam int LEVEL_W    = 8;
  localparam int PIN_IDX_W  = 3;
  localparam int KIND_W     = 2;
  localparam int HELD_W     = 14;
  localparam int CFG_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CMP_W      = ((COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W) + 1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Register reset values
  localparam logic [7:0]       RST_PIN_MASK   = 8'hFF;
  localparam logic [CFG_W-1:0] RST_TICK_STEP  = CFG_W'(1);
  localparam logic [CFG_W-1:0] RST_CLICK_LIM  = CFG_W'(50);
  localparam logic [CFG_W-1:0] RST_PRESS_THR  = CFG_W'(100);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIN_MASK    = 3'd0,
    CFG_ACTIVE_HIGH = 3'd1,
    CFG_TICK_STEP   = 3'd2,
    CFG_CLICK_EN    = 3'd3,
    CFG_CLICK_LIM   = 3'd4,
    CFG_HOLD_EN     = 3'd5,
    CFG_PRESS_THR   = 3'd6
  } cfg_idx_e;

  // Pin machine states
  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_DEB_ACT  = 4'b0010,
    ST_ACTIVE   = 4'b0100,
    ST_DEB_IDLE = 4'b1000
  } pin_state_e;

  // Event codes
  typedef enum logic [KIND_W-1:0] {
    EV_CLICK = 2'd0,
    EV_HELD  = 2'd1,
    EV_LONG  = 2'd2
  } event_kind_e;

  // Configuration set
  typedef struct packed {
    logic [7:0]       pin_mask;
    logic             active_high;
    logic [CFG_W-1:0] tick_step;
    logic             click_en;
    logic [CFG_W-1:0] click_limit;
    logic             hold_en;
    logic [CFG_W-1:0] press_thr;
  } cfg_t;

  // Events of one sample: slot 2p+1 is the click or held event of pin p,
  // slot 2p its long release
  typedef struct packed {
    logic [SLOTS-1:0]                ev_mask;
    logic [NUM_PINS-1:0]             held;
    logic [NUM_PINS-1:0][HELD_W-1:0] count;
  } rec_t;

endpackage

>>> sv/button_click_hold_detector.sv
// ----------------------------------------------------------------------------
// button_click_hold_detector
// Eight-pin button click / hold detector with queue-style ports.
// ----------------------------------------------------------------------------
// Path: a sample's results pass the queue, the record register and result stage.
// Throughput: one sample a cycle while the queue has room; results leave one
//   a cycle unless pop stalls them; a sample yields up to 16 results.
// Reset: pin machines idle with count zero, registers at their reset values,
//   queue and result stage empty; no clearing pass.
module button_click_hold_detector import bchd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  logic [LEVEL_W-1:0]   port_levels_i,
  input  logic                 pop,
  output logic                 empty,
  output logic [PIN_IDX_W-1:0] pin_index_o,
  output logic [KIND_W-1:0]    event_kind_o,
  output logic [HELD_W-1:0]    held_count_o,
  output logic                 last_event_o
);

  cfg_t cfg_q;
  logic take;
  logic rec_valid;
  rec_t rec;
  logic q_rd;
  rec_t q_data;
  logic q_full;
  logic q_empty;

  // Decode register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pin_mask    <= RST_PIN_MASK;
      cfg_q.active_high <= 1'b0;
      cfg_q.tick_step   <= RST_TICK_STEP;
      cfg_q.click_en    <= 1'b1;
      cfg_q.click_limit <= RST_CLICK_LIM;
      cfg_q.hold_en     <= 1'b1;
      cfg_q.press_thr   <= RST_PRESS_THR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PIN_MASK:    cfg_q.pin_mask    <= cfg_data_i[7:0];
        CFG_ACTIVE_HIGH: cfg_q.active_high <= cfg_data_i[0];
        CFG_TICK_STEP:   cfg_q.tick_step   <= cfg_data_i;
        CFG_CLICK_EN:    cfg_q.click_en    <= cfg_data_i[0];
        CFG_CLICK_LIM:   cfg_q.click_limit <= cfg_data_i;
        CFG_HOLD_EN:     cfg_q.hold_en     <= cfg_data_i[0];
        CFG_PRESS_THR:   cfg_q.press_thr   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Accept a request while the queue has room
  assign full = q_full;
  assign take = push && !q_full;

  bchd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .take_i        (take),
    .port_levels_i (port_levels_i),
    .rec_valid_o   (rec_valid),
    .rec_o         (rec)
  );

  bchd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rec_valid),
    .wr_data_i (rec),
    .rd_i      (q_rd),
    .rd_data_o (q_data),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  bchd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (q_data),
    .q_rd_o       (q_rd),
    .pop          (pop),
    .empty        (empty),
    .pin_index_o  (pin_index_o),
    .event_kind_o (event_kind_o),
    .held_count_o (held_count_o),
    .last_event_o (last_event_o)
  );

endmodule

>>> sv/bchd_front.sv
// ----------------------------------------------------------------------------
// bchd_front
// Runs the watched pin machines on one sample and packs the resulting events.
// ----------------------------------------------------------------------------
module bchd_front import bchd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               take_i,
  input  logic [LEVEL_W-1:0] port_levels_i,
  output logic               rec_valid_o,
  output rec_t               rec_o
);

  pin_state_e                    st_q [NUM_PINS];
  pin_state_e                    st_d [NUM_PINS];
  logic [COUNT_WIDTH-1:0]        cnt_q [NUM_PINS];
  logic [COUNT_WIDTH-1:0]        cnt_d [NUM_PINS];

  // Next state and events of every pin, all pins in parallel
  always_comb begin
    logic                   pressed;
    logic [CMP_W-1:0]       sum;
    logic [COUNT_WIDTH-1:0] cnt_adv;
    logic                   thr_hit;
    logic                   clk_hit;
    rec_o = '0;
    for (int p = 0; p < NUM_PINS; p++) begin
      st_d[p]  = st_q[p];
      cnt_d[p] = cnt_q[p];
      pressed  = (port_levels_i[p] == cfg_i.active_high);
      sum      = CMP_W'(cnt_q[p]) + CMP_W'(cfg_i.tick_step);
      cnt_adv  = (sum > CMP_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
      thr_hit  = cfg_i.hold_en && (CMP_W'(cfg_i.press_thr) <= CMP_W'(cnt_adv));
      clk_hit  = cfg_i.click_en && (CMP_W'(cfg_i.click_limit) >= CMP_W'(cnt_adv));
      rec_o.count[p] = HELD_W'(cnt_adv);
      if (cfg_i.pin_mask[p]) begin
        cnt_d[p] = cnt_adv;
        unique case (st_q[p])
          ST_IDLE: begin
            if (pressed) begin
              st_d[p]  = ST_DEB_ACT;
              cnt_d[p] = '0;
            end
          end
          ST_DEB_ACT: begin
            if (pressed) begin
              st_d[p]              = ST_ACTIVE;
              rec_o.ev_mask[2*p+1] = thr_hit;
              rec_o.held[p]        = 1'b1;
            end else begin
              st_d[p]  = ST_IDLE;
              cnt_d[p] = '0;
            end
          end
          ST_ACTIVE: begin
            if (pressed) begin
              rec_o.ev_mask[2*p+1] = thr_hit;
              rec_o.held[p]        = 1'b1;
            end else begin
              st_d[p] = ST_DEB_IDLE;
            end
          end
          ST_DEB_IDLE: begin
            if (pressed) begin
              st_d[p] = ST_ACTIVE;
            end else begin
              rec_o.ev_mask[2*p+1] = clk_hit;
              rec_o.ev_mask[2*p]   = thr_hit;
              st_d[p]              = ST_IDLE;
              cnt_d[p]             = '0;
            end
          end
          default: begin
            st_d[p]  = ST_IDLE;
            cnt_d[p] = '0;
          end
        endcase
      end
    end
  end

  // Queue the sample only when it raises an event
  assign rec_valid_o = take_i && (|rec_o.ev_mask);

  // Advance the pin machines on each accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PINS; p++) begin
        st_q[p]  <= ST_IDLE;
        cnt_q[p] <= '0;
      end
    end else if (take_i) begin
      for (int p = 0; p < NUM_PINS; p++) begin
        st_q[p]  <= st_d[p];
        cnt_q[p] <= cnt_d[p];
      end
    end
  end

endmodule

>>> sv/bchd_queue.sv
// ----------------------------------------------------------------------------
// bchd_queue
// Short queue of event records between the front and the back.
// ----------------------------------------------------------------------------
module bchd_queue import bchd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  rec_t wr_data_i,
  input  logic rd_i,
  output rec_t rd_data_o,
  output logic full_o,
  output logic empty_o
);

  rec_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // Store a record
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (rd_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

>>> sv/bchd_back.sv
// ----------------------------------------------------------------------------
// bchd_back
// Walks the events of each record, highest slot first, into the result stage.
// ----------------------------------------------------------------------------
module bchd_back import bchd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  rec_t                 q_data_i,
  output logic                 q_rd_o,
  input  logic                 pop,
  output logic                 empty,
  output logic [PIN_IDX_W-1:0] pin_index_o,
  output logic [KIND_W-1:0]    event_kind_o,
  output logic [HELD_W-1:0]    held_count_o,
  output logic                 last_event_o
);

  rec_t                 cur_q;
  logic                 out_valid_q;
  logic [PIN_IDX_W-1:0] pin_q;
  event_kind_e          kind_q;
  logic [HELD_W-1:0]    count_q;
  logic                 last_q;

  logic                 advance;
  logic                 have_ev;
  logic [SLOTS-1:0]     rest;
  logic [PIN_IDX_W-1:0] sel_pin;
  event_kind_e          sel_kind;
  logic [HELD_W-1:0]    sel_count;
  logic                 load;

  // Pick the highest pending slot
  always_comb begin
    sel_pin   = '0;
    sel_kind  = EV_CLICK;
    sel_count = '0;
    rest      = cur_q.ev_mask;
    for (int s = 0; s < SLOTS; s++) begin
      if (cur_q.ev_mask[s]) begin
        sel_pin   = PIN_IDX_W'(s >> 1);
        sel_count = cur_q.count[s >> 1];
        if ((s & 1) == 0) begin
          sel_kind = EV_LONG;
        end else if (cur_q.held[s >> 1]) begin
          sel_kind = EV_HELD;
        end else begin
          sel_kind = EV_CLICK;
        end
        rest = cur_q.ev_mask & ~(SLOTS'(1) << s);
      end
    end
  end

  assign have_ev = |cur_q.ev_mask;
  assign advance = !out_valid_q || pop;
  // Fetch the next record once the current one is used up
  assign load    = !q_empty_i && (!have_ev || (advance && (rest == '0)));
  assign q_rd_o  = load;

  // Hold the record being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else if (load) begin
      cur_q <= q_data_i;
    end else if (advance && have_ev) begin
      cur_q.ev_mask <= rest;
    end
  end

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= have_ev;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && have_ev) begin
      pin_q   <= sel_pin;
      kind_q  <= sel_kind;
      count_q <= sel_count;
      last_q  <= (rest == '0);
    end
  end

  assign empty        = !out_valid_q;
  assign pin_index_o  = pin_q;
  assign event_kind_o = kind_q;
  assign held_count_o = count_q;
  assign last_event_o = last_q;

endmodule

>>> sv/bchd_checker.sv
// ----------------------------------------------------------------------------
// bchd_checker
// Port-level checks of the detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bchd_checker import bchd_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 pop,
  input logic                 empty,
  input logic [PIN_IDX_W-1:0] pin_index_o,
  input logic [KIND_W-1:0]    event_kind_o,
  input logic [HELD_W-1:0]    held_count_o,
  input logic                 last_event_o
);

  // Nothing shows as waiting while reset is held
  `ASSERT_ALL(a_empty_in_reset, clk_i, !rst_ni |-> empty)

  // A stalled request holds its fields
  `ASSERT_RST(a_hold_stalled, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable({pin_index_o, event_kind_o, held_count_o, last_event_o})))

  // Within a sample the next event follows at once, from a lower pin, or long after click
  `ASSERT_RST(a_order, clk_i, rst_ni, (!empty && pop && !last_event_o) |=> (!empty && ((pin_index_o < $past(pin_index_o)) || ((pin_index_o == $past(pin_index_o)) && (event_kind_o == EV_LONG) && ($past(event_kind_o) == EV_CLICK)))))

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pop          (pop),
  .empty        (empty),
  .pin_index_o  (pin_index_o),
  .event_kind_o (event_kind_o),
  .held_count_o (held_count_o),
  .last_event_o (last_event_o)
);

>>> tb/button_click_hold_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_hold_detector_tb
// Drives port samples through the queue-style request side and checks every
// click, held and long-release event against a cycle-free model of the eight
// pin machines. Directed sequences cover counter saturation, bounces, zero
// step, masking and disabled events. Random sequences follow under several
// settings and idling patterns.
// ----------------------------------------------------------------------------
module button_click_hold_detector_tb;
  import bchd_pkg::*;

  // Expected event of one pin
  typedef struct {
    logic [PIN_IDX_W-1:0] pin;
    event_kind_e          kind;
    logic [HELD_W-1:0]    count;
    logic                 last;
  } btn_event_t;

  localparam cfg_t RESET_CFG = '{pin_mask: RST_PIN_MASK, active_high: 1'b0,
                                 tick_step: RST_TICK_STEP, click_en: 1'b1,
                                 click_limit: RST_CLICK_LIM, hold_en: 1'b1,
                                 press_thr: RST_PRESS_THR};

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 push;
  logic                 full;
  logic [LEVEL_W-1:0]   port_levels_i;
  logic                 pop;
  logic                 empty;
  logic [PIN_IDX_W-1:0] pin_index_o;
  logic [KIND_W-1:0]    event_kind_o;
  logic [HELD_W-1:0]    held_count_o;
  logic                 last_event_o;

  // Tracked pin machines and settings
  pin_state_e             pin_st  [NUM_PINS];
  logic [COUNT_WIDTH-1:0] pin_cnt [NUM_PINS];
  cfg_t                   cur_cfg;
  btn_event_t             pending_events[$];

  // Random press plan per pin
  logic                   plan_pressed [NUM_PINS];
  int                     plan_left    [NUM_PINS];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  button_click_hold_detector DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .port_levels_i (port_levels_i),
    .pop           (pop),
    .empty         (empty),
    .pin_index_o   (pin_index_o),
    .event_kind_o  (event_kind_o),
    .held_count_o  (held_count_o),
    .last_event_o  (last_event_o)
  );

  always #2 clk_i = ~clk_i;

  // Count and print one mismatch
  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void queue_event(input int p, input event_kind_e kind, input int cnt);
    pending_events.push_back('{pin: PIN_IDX_W'(p), kind: kind, count: HELD_W'(cnt),
                               last: 1'b0});
  endfunction

  // Advance every watched pin machine by one sample and queue its events
  function automatic void track_buttons(input logic [LEVEL_W-1:0] lv);
    int   p;
    int   cnt;
    int   first;
    logic pressed;
    first = pending_events.size();
    for (p = NUM_PINS - 1; p >= 0; p--) begin
      if (cur_cfg.pin_mask[p]) begin
        pressed = (lv[p] == cur_cfg.active_high);
        cnt = int'(pin_cnt[p]);
        if (int'(cur_cfg.tick_step) >= int'(COUNT_MAX) - cnt) begin
          cnt = int'(COUNT_MAX);
        end else begin
          cnt = cnt + int'(cur_cfg.tick_step);
        end
        case (pin_st[p])
          ST_IDLE: begin
            if (pressed) begin
              pin_st[p] = ST_DEB_ACT;
              cnt = 0;
            end
          end
          ST_DEB_ACT, ST_ACTIVE: begin
            if (pressed) begin
              pin_st[p] = ST_ACTIVE;
              if (cur_cfg.hold_en && int'(cur_cfg.press_thr) <= cnt)
                queue_event(p, EV_HELD, cnt);
            end else if (pin_st[p] == ST_DEB_ACT) begin
              pin_st[p] = ST_IDLE;
              cnt = 0;
            end else begin
              pin_st[p] = ST_DEB_IDLE;
            end
          end
          default: begin
            if (pressed) begin
              pin_st[p] = ST_ACTIVE;
            end else begin
              if (cur_cfg.click_en && int'(cur_cfg.click_limit) >= cnt)
                queue_event(p, EV_CLICK, cnt);
              if (cur_cfg.hold_en && int'(cur_cfg.press_thr) <= cnt)
                queue_event(p, EV_LONG, cnt);
              pin_st[p] = ST_IDLE;
              cnt = 0;
            end
          end
        endcase
        pin_cnt[p] = COUNT_WIDTH'(cnt);
      end
    end
    if (pending_events.size() > first)
      pending_events[pending_events.size() - 1].last = 1'b1;
  endfunction

  // Offer one sample; the request stays high after acceptance
  task automatic send_sample(input logic [LEVEL_W-1:0] lv);
    logic ok;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      port_levels_i <= LEVEL_W'($urandom);
      @(posedge clk_i);
    end
    push <= 1'b1;
    port_levels_i <= lv;
    forever begin
      @(negedge clk_i);
      ok = !full;
      @(posedge clk_i);
      if (ok) break;
    end
    track_buttons(lv);
  endtask

  // Drop the request, drain all events and let the pipeline empty
  task automatic settle_block();
    push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Write every register; only called with the block idle
  task automatic apply_config(input cfg_t c);
    cfg_we_i <= 1'b1;
    write_reg(CFG_PIN_MASK,    CFG_W'(c.pin_mask));
    write_reg(CFG_ACTIVE_HIGH, CFG_W'(c.active_high));
    write_reg(CFG_TICK_STEP,   c.tick_step);
    write_reg(CFG_CLICK_EN,    CFG_W'(c.click_en));
    write_reg(CFG_CLICK_LIM,   c.click_limit);
    write_reg(CFG_HOLD_EN,     CFG_W'(c.hold_en));
    write_reg(CFG_PRESS_THR,   c.press_thr);
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    int   pick;
    c.pin_mask    = ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
    c.active_high = 1'($urandom_range(1));
    pick = $urandom_range(9);
    if (pick == 0)      c.tick_step = '0;
    else if (pick == 1) c.tick_step = CFG_W'(COUNT_MAX);
    else if (pick == 2) c.tick_step = CFG_W'($urandom);
    else                c.tick_step = CFG_W'($urandom_range(1, 8));
    c.click_en    = ($urandom_range(3) != 0);
    c.hold_en     = ($urandom_range(3) != 0);
    pick = $urandom_range(9);
    c.click_limit = (pick == 0) ? {CFG_W{1'b1}} : (pick == 1) ? '0
                                : CFG_W'($urandom_range(0, 40));
    pick = $urandom_range(9);
    c.press_thr   = (pick == 0) ? {CFG_W{1'b1}} : (pick == 1) ? '0
                                : CFG_W'($urandom_range(0, 60));
    return c;
  endfunction

  // Mostly steady presses of random length, with one-sample noise and bounces
  function automatic logic [LEVEL_W-1:0] next_levels();
    logic [LEVEL_W-1:0] lv;
    logic               b;
    int                 p;
    if ($urandom_range(9) == 0) return LEVEL_W'($urandom);
    for (p = 0; p < NUM_PINS; p++) begin
      if (plan_left[p] == 0) begin
        plan_pressed[p] = ~plan_pressed[p];
        plan_left[p] = $urandom_range(1, 14);
      end
      plan_left[p]--;
      b = plan_pressed[p];
      if ($urandom_range(19) == 0) b = ~b;
      lv[p] = cur_cfg.active_high ? b : ~b;
    end
    return lv;
  endfunction

  // Release every pin at reset settings: eight clicks at once
  task automatic test_reset_click();
    send_sample(8'h00);
    send_sample(8'h00);
    send_sample(8'hFF);
    send_sample(8'hFF);
  endtask

  // Saturating counter with full limits, then bounces in both debounce states
  task automatic test_saturation();
    cfg_t c;
    logic [LEVEL_W-1:0] seq [10] = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF,
                                     8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF};
    settle_block();
    c = RESET_CFG;
    c.active_high = 1'b1;
    c.tick_step   = CFG_W'(COUNT_MAX);
    c.click_limit = {CFG_W{1'b1}};
    c.press_thr   = '0;
    apply_config(c);
    foreach (seq[i]) send_sample(seq[i]);
  endtask

  // Zero step keeps the count at zero; zero limits still fire
  task automatic test_zero_step();
    cfg_t c;
    settle_block();
    c = RESET_CFG;
    c.pin_mask    = 8'h81;
    c.tick_step   = '0;
    c.click_limit = '0;
    c.press_thr   = '0;
    apply_config(c);
    send_sample(8'h00);
    send_sample(8'h00);
    send_sample(8'hFF);
    send_sample(8'hFF);
  endtask

  // Unwatched pins freeze mid-press and resume with their old count
  task automatic test_mask_freeze();
    cfg_t c;
    settle_block();
    c = RESET_CFG;
    c.active_high = 1'b1;
    c.tick_step   = CFG_W'(3);
    c.click_limit = CFG_W'(10);
    c.press_thr   = CFG_W'(5);
    apply_config(c);
    send_sample(8'hF0);
    send_sample(8'hF0);
    settle_block();
    c.pin_mask = 8'h0F;
    apply_config(c);
    send_sample(8'h00);
    settle_block();
    c.pin_mask = 8'hFF;
    c.click_en = 1'b0;
    apply_config(c);
    send_sample(8'h00);
    send_sample(8'h00);
  endtask

  // Two random settings under one idling pattern
  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input int n_items);
    int seg;
    int k;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (seg = 0; seg < 2; seg++) begin
      settle_block();
      apply_config(random_cfg());
      for (k = 0; k < n_items; k++) send_sample(next_levels());
    end
  endtask

  // Receiver: stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each accepted event against the oldest expectation
  always @(negedge clk_i) begin
    btn_event_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event pin %0d kind %0d count %0d",
                                  pin_index_o, event_kind_o, held_count_o));
      end else begin
        want = pending_events.pop_front();
        if (pin_index_o !== want.pin)
          report_mismatch($sformatf("pin_index got %0d want %0d", pin_index_o, want.pin));
        if (event_kind_o !== want.kind)
          report_mismatch($sformatf("event_kind got %0d want %0d", event_kind_o,
                                    want.kind));
        if (held_count_o !== want.count)
          report_mismatch($sformatf("held_count got %0d want %0d", held_count_o,
                                    want.count));
        if (last_event_o !== want.last)
          report_mismatch($sformatf("last_event got %0b want %0b", last_event_o,
                                    want.last));
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_PIN_MASK;
    cfg_data_i    <= '0;
    push          <= 1'b0;
    port_levels_i <= '0;
    cur_cfg = RESET_CFG;
    for (int p = 0; p < NUM_PINS; p++) begin
      pin_st[p]       = ST_IDLE;
      pin_cnt[p]      = '0;
      plan_pressed[p] = 1'b0;
      plan_left[p]    = 1;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_click();
    test_saturation();
    test_zero_step();
    test_mask_freeze();
    test_random_phase(0, 0, 44);
    test_random_phase(60, 0, 44);
    test_random_phase(0, 60, 44);
    test_random_phase(10, 10, 44);

    // Drain and let the last samples leave the pipeline
    settle_block();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
